FILE: rtl/core/lr4_crossover_filter_macros.svh
`ifndef LR4_CROSSOVER_FILTER_MACROS_SVH
`define LR4_CROSSOVER_FILTER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LR4X_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define LR4X_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lr4x_pkg.sv
`timescale 1ns / 1ps

package lr4x_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 28;
    localparam int SECTIONS       = 2;

    localparam int SIG_W      = 32;
    localparam int COEF_W     = 32;
    localparam int HEAD_FRAC  = (SIG_W - SAMPLE_BITS) / 2;
    localparam int PROD_W     = SIG_W + COEF_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;
    localparam int TAP_W      = 3;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

    typedef logic signed [SIG_W-1:0]  t_sig;
    typedef logic signed [COEF_W-1:0] t_coef;

    typedef enum logic [TAP_W-1:0] {
        TAP_B0 = 3'd0,
        TAP_B1 = 3'd1,
        TAP_B2 = 3'd2,
        TAP_A1 = 3'd3,
        TAP_A2 = 3'd4
    } t_tap;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0 = 3'd0,
        CFG_B1 = 3'd1,
        CFG_B2 = 3'd2,
        CFG_A1 = 3'd3,
        CFG_A2 = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic clr_acc;
        logic mul_en;
        t_tap tap;
        logic acc_en;
        logic round;
        logic rotate;
        logic out_load;
    } t_ctl;

endpackage

FILE: rtl/core/lr4x_if.sv
`timescale 1ns / 1ps

interface lr4x_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lr4x_pkg::SAMPLE_BITS-1:0] sample_in;
    logic                                   start_req;

    modport source (output valid, output sample_in, output start_req, input ready);
    modport sink   (input valid, input sample_in, input start_req, output ready);
endinterface

interface lr4x_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lr4x_pkg::SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: rtl/core/lr4x_ctrl.sv
`timescale 1ns / 1ps

module lr4x_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output lr4x_pkg::t_ctl  o_ctl
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MAC    = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_ROUND  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    localparam logic [lr4x_pkg::SEC_W-1:0] LAST_SEC =
        lr4x_pkg::SEC_W'(lr4x_pkg::SECTIONS - 1);

    t_state                       r_state, n_state;
    lr4x_pkg::t_tap               r_tap, n_tap;
    logic [lr4x_pkg::SEC_W-1:0]   r_sec, n_sec;
    logic                         r_out_valid, n_out_valid;
    logic                         w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_tap       = r_tap;
        n_sec       = r_sec;
        o_ctl       = '0;
        o_ctl.tap   = r_tap;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_tap      = lr4x_pkg::TAP_B0;
                    n_sec      = '0;
                    n_state    = ST_MAC;
                end
            end
            ST_MAC: begin
                // one product per cycle, summed into the accumulator in the cycle after the multiply
                o_ctl.mul_en  = 1'b1;
                o_ctl.clr_acc = (r_tap == lr4x_pkg::TAP_B0);
                o_ctl.acc_en  = (r_tap != lr4x_pkg::TAP_B0);
                if (r_tap == lr4x_pkg::TAP_A2) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_tap = lr4x_pkg::t_tap'(r_tap + lr4x_pkg::TAP_W'(1));
                end
            end
            ST_DRAIN: begin
                o_ctl.acc_en = 1'b1;
                n_state      = ST_ROUND;
            end
            ST_ROUND: begin
                o_ctl.round  = 1'b1;
                o_ctl.rotate = 1'b1;
                if (r_sec == LAST_SEC) begin
                    n_state = ST_FINISH;
                end else begin
                    n_sec   = r_sec + lr4x_pkg::SEC_W'(1);
                    n_tap   = lr4x_pkg::TAP_B0;
                    n_state = ST_MAC;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    o_ctl.rotate   = 1'b1;
                    o_ctl.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap       <= lr4x_pkg::TAP_B0;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tap       <= n_tap;
            r_sec       <= n_sec;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/core/lr4x_datapath.sv
`timescale 1ns / 1ps

module lr4x_datapath (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  lr4x_pkg::t_ctl                           i_ctl,
    input  logic                                     i_cfg_we,
    input  logic [lr4x_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [lr4x_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    input  logic signed [lr4x_pkg::SAMPLE_BITS-1:0]  i_sample_in,
    input  logic                                     i_start_req,
    output logic signed [lr4x_pkg::SAMPLE_BITS-1:0]  o_sample_out
);

    localparam int SIG_W  = lr4x_pkg::SIG_W;
    localparam int ACC_W  = lr4x_pkg::ACC_W;
    localparam int CF     = lr4x_pkg::COEF_FRAC_BITS;
    localparam int HF     = lr4x_pkg::HEAD_FRAC;
    localparam int SB     = lr4x_pkg::SAMPLE_BITS;
    localparam int NSEC   = lr4x_pkg::SECTIONS;
    localparam int QS_W   = ACC_W - CF;
    localparam int FIN_W  = SIG_W + 1;
    localparam int QF_W   = FIN_W - HF;

    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) << (CF - 1);
    localparam logic signed [FIN_W-1:0] FIN_RND = FIN_W'((1 << HF) / 2);
    localparam logic [SIG_W-1:0]        SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic [SIG_W-1:0]        SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic [SB-1:0]           OUT_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0]           OUT_MIN = {1'b1, {(SB-1){1'b0}}};

    lr4x_pkg::t_coef r_b0, r_b1, r_b2, r_a1, r_a2;

    // signal history per node: node 0 is the filter input, node k the output of
    // section k-1; the line rotates once per section plus once at the end so the
    // section at work always sees its input node at entry 0 and output node at 1
    lr4x_pkg::t_sig r_h1 [NSEC+1];
    lr4x_pkg::t_sig r_h2 [NSEC+1];

    lr4x_pkg::t_sig               r_x;
    logic signed [SIG_W-1:0]      w_x_in;
    lr4x_pkg::t_coef              w_coef;
    lr4x_pkg::t_sig               w_data;
    logic signed [lr4x_pkg::PROD_W-1:0] r_prod;
    logic                         r_sub;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ACC_W-1:0]      w_prod_ext;
    logic signed [ACC_W-1:0]      w_acc_rnd;
    logic [QS_W-1:0]              w_sec_q;
    logic [QS_W-SIG_W:0]          w_sec_top;
    logic [SIG_W-1:0]             w_sec_y;
    logic signed [FIN_W-1:0]      w_fin;
    logic [QF_W-1:0]              w_fin_q;
    logic [QF_W-SB:0]             w_fin_top;
    logic [SB-1:0]                w_fin_y;
    logic [SB-1:0]                r_sample_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= lr4x_pkg::COEF_ONE;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lr4x_pkg::CFG_B0: r_b0 <= i_cfg_data;
                lr4x_pkg::CFG_B1: r_b1 <= i_cfg_data;
                lr4x_pkg::CFG_B2: r_b2 <= i_cfg_data;
                lr4x_pkg::CFG_A1: r_a1 <= i_cfg_data;
                lr4x_pkg::CFG_A2: r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NSEC; i++) begin
                r_h1[i] <= '0;
                r_h2[i] <= '0;
            end
        end else if (i_ctl.load && i_start_req) begin
            for (int i = 0; i <= NSEC; i++) begin
                r_h1[i] <= '0;
                r_h2[i] <= '0;
            end
        end else if (i_ctl.rotate) begin
            for (int i = 0; i < NSEC; i++) begin
                r_h1[i] <= r_h1[i+1];
                r_h2[i] <= r_h2[i+1];
            end
            r_h1[NSEC] <= r_x;
            r_h2[NSEC] <= r_h1[0];
        end
    end

    assign w_x_in = SIG_W'(i_sample_in);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= w_x_in <<< HF;
        end else if (i_ctl.round) begin
            r_x <= w_sec_y;
        end
    end

    always_comb begin
        case (i_ctl.tap)
            lr4x_pkg::TAP_B0: begin w_coef = r_b0; w_data = r_x;     end
            lr4x_pkg::TAP_B1: begin w_coef = r_b1; w_data = r_h1[0]; end
            lr4x_pkg::TAP_B2: begin w_coef = r_b2; w_data = r_h2[0]; end
            lr4x_pkg::TAP_A1: begin w_coef = r_a1; w_data = r_h1[1]; end
            lr4x_pkg::TAP_A2: begin w_coef = r_a2; w_data = r_h2[1]; end
            default:          begin w_coef = '0;   w_data = '0;      end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_coef * w_data;
            // feedback terms are subtracted
            r_sub  <= (i_ctl.tap == lr4x_pkg::TAP_A1) || (i_ctl.tap == lr4x_pkg::TAP_A2);
        end
    end

    assign w_prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_acc) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_sub ? (r_acc - w_prod_ext) : (r_acc + w_prod_ext);
        end
    end

    // round half up, drop coefficient fraction, saturate to the section width
    assign w_acc_rnd = r_acc + ACC_RND;
    assign w_sec_q   = w_acc_rnd[ACC_W-1:CF];
    assign w_sec_top = w_sec_q[QS_W-1:SIG_W-1];

    always_comb begin
        if ((&w_sec_top) || !(|w_sec_top)) begin
            w_sec_y = w_sec_q[SIG_W-1:0];
        end else begin
            w_sec_y = w_sec_q[QS_W-1] ? SIG_MIN : SIG_MAX;
        end
    end

    // drop headroom fraction bits with round half up, saturate to sample width
    assign w_fin     = FIN_W'(r_x) + FIN_RND;
    assign w_fin_q   = w_fin[FIN_W-1:HF];
    assign w_fin_top = w_fin_q[QF_W-1:SB-1];

    always_comb begin
        if ((&w_fin_top) || !(|w_fin_top)) begin
            w_fin_y = w_fin_q[SB-1:0];
        end else begin
            w_fin_y = w_fin_q[QF_W-1] ? OUT_MIN : OUT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_sample_out <= w_fin_y;
        end
    end

    assign o_sample_out = r_sample_out;

endmodule

FILE: rtl/core/lr4_crossover_filter.sv
`timescale 1ns / 1ps

// channel    dir   handshake       payload
// i_in       in    valid / ready   sample_in (24b signed), start_req (1b)
// o_out      out   valid / ready   sample_out (24b signed)
// i_cfg_*    in    write enable    i_cfg_idx selects b0 b1 b2 a1 a2, i_cfg_data 32b
//
// per sample: the transfer is taken in idle, then per section five products go
// through the single shared 32x32 multiplier, the accumulator is drained and the
// sum is rounded, then the output register is written.
// the output register frees i_in while a result waits; the last step holds
// only if the previous result is still not taken.
// synchronous reset restores pass-through coefficients and zero history.
module lr4_crossover_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lr4x_in_if.sink                             i_in,
    lr4x_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [lr4x_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lr4x_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lr4x_pkg::t_ctl w_ctl;
    logic           w_in_ready;
    logic           w_out_valid;

    lr4x_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_ctl       (w_ctl)
    );

    lr4x_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_in.sample_in),
        .i_start_req  (i_in.start_req),
        .o_sample_out (o_out.sample_out)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

FILE: rtl/core/lr4x_checker.sv
`timescale 1ns / 1ps

module lr4x_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [lr4x_pkg::SAMPLE_BITS-1:0]  i_out_sample
);

`include "lr4_crossover_filter_macros.svh"

    `LR4X_ASSERT_NEXT(a_out_valid_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `LR4X_ASSERT_NEXT(a_out_data_hold, i_out_valid && !i_out_ready, $stable(i_out_sample), "result changed while stalled")
    // the block works on one sample at a time
    `LR4X_ASSERT_NEXT(a_busy_after_in, i_in_valid && i_in_ready, !i_in_ready, "input taken while busy")
    // a fresh result only comes out of a sample in progress
    `LR4X_ASSERT_NOW(a_out_from_work, $rose(i_out_valid), $past(!i_in_ready), "result without work")

endmodule

bind lr4_crossover_filter lr4x_checker u_lr4x_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WIDE        = 72;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 40;
    localparam int SIDE_SRC    = 0;
    localparam int SIDE_SNK    = 1;

    typedef logic signed [lr4x_pkg::SAMPLE_BITS-1:0] t_smp;
    typedef logic signed [WIDE-1:0]                  t_wide;

    localparam t_smp SAMPLE_MAX = {1'b0, {(lr4x_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam t_smp SAMPLE_MIN = {1'b1, {(lr4x_pkg::SAMPLE_BITS-1){1'b0}}};
    localparam lr4x_pkg::t_coef COEF_MAX = {1'b0, {(lr4x_pkg::COEF_W-1){1'b1}}};
    localparam lr4x_pkg::t_coef COEF_MIN = {1'b1, {(lr4x_pkg::COEF_W-1){1'b0}}};

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [lr4x_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lr4x_pkg::CFG_DATA_W-1:0] i_cfg_data;

    lr4x_in_if  smp_in_if ();
    lr4x_out_if smp_out_if ();

    lr4_crossover_filter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (smp_in_if),
        .o_out      (smp_out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // filter state mirrored on the bench side
    lr4x_pkg::t_coef tap_b0, tap_b1, tap_b2, tap_a1, tap_a2;
    lr4x_pkg::t_sig  x_hist [lr4x_pkg::SECTIONS][2];
    lr4x_pkg::t_sig  y_hist [lr4x_pkg::SECTIONS][2];

    t_smp  filtered_q [$];
    int    err_count;
    int    cycle_count;
    int    calm_left [2];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic t_wide clamp(input t_wide v, input int bits);
        t_wide top;
        top = t_wide'(1);
        top = (top <<< (bits - 1)) - t_wide'(1);
        if (v > top) return top;
        if (v < -top - t_wide'(1)) return -top - t_wide'(1);
        return v;
    endfunction

    function automatic t_wide mul_wide(input lr4x_pkg::t_coef c, input lr4x_pkg::t_sig s);
        t_wide wc;
        t_wide ws;
        wc = t_wide'(c);
        ws = t_wide'(s);
        return wc * ws;
    endfunction

    function automatic lr4x_pkg::t_sig run_section(input lr4x_pkg::t_sig x, x1, x2, y1, y2);
        t_wide acc;
        acc = mul_wide(tap_b0, x) + mul_wide(tap_b1, x1) + mul_wide(tap_b2, x2)
            - mul_wide(tap_a1, y1) - mul_wide(tap_a2, y2);
        // round half up, then floor shift back to signal units
        acc = (acc + (t_wide'(1) <<< (lr4x_pkg::COEF_FRAC_BITS - 1)))
              >>> lr4x_pkg::COEF_FRAC_BITS;
        acc = clamp(acc, lr4x_pkg::SIG_W);
        return acc[lr4x_pkg::SIG_W-1:0];
    endfunction

    function automatic void clear_history();
        for (int s = 0; s < lr4x_pkg::SECTIONS; s++) begin
            for (int k = 0; k < 2; k++) begin
                x_hist[s][k] = '0;
                y_hist[s][k] = '0;
            end
        end
    endfunction

    function automatic t_smp crossover_predict(input t_smp smp, input bit clr);
        lr4x_pkg::t_sig x;
        lr4x_pkg::t_sig y;
        t_wide          w;
        if (clr) clear_history();
        x = lr4x_pkg::t_sig'(smp);
        x = x <<< lr4x_pkg::HEAD_FRAC;
        for (int s = 0; s < lr4x_pkg::SECTIONS; s++) begin
            y = run_section(x, x_hist[s][0], x_hist[s][1], y_hist[s][0], y_hist[s][1]);
            x_hist[s][1] = x_hist[s][0];
            x_hist[s][0] = x;
            y_hist[s][1] = y_hist[s][0];
            y_hist[s][0] = y;
            x = y;
        end
        w = t_wide'(x);
        w = (w + (t_wide'(1) <<< (lr4x_pkg::HEAD_FRAC - 1))) >>> lr4x_pkg::HEAD_FRAC;
        w = clamp(w, lr4x_pkg::SAMPLE_BITS);
        return w[lr4x_pkg::SAMPLE_BITS-1:0];
    endfunction

    // mostly random gaps, with runs of back-to-back transfers now and then
    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left[side] = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic t_smp pick_sample();
        t_smp v;
        case ($urandom_range(0, 9))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2, 3: v = t_smp'($urandom_range(0, 511) - 256);
            default: v = t_smp'($urandom());
        endcase
        return v;
    endfunction

    function automatic lr4x_pkg::t_coef rand_coef();
        if ($urandom_range(0, 2) == 0) return $urandom();
        // within +-1.0 most of the time
        return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    endfunction

    // valid stays up across back-to-back transfers
    task automatic push_sample(input t_smp smp, input bit clr);
        int gap;
        gap = draw_wait(SIDE_SRC);
        if (gap > 0) begin
            smp_in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_in_if.valid     <= 1'b1;
        smp_in_if.sample_in <= smp;
        smp_in_if.start_req <= clr;
        @(posedge i_clk);
        while (smp_in_if.ready !== 1'b1) @(posedge i_clk);
        filtered_q = {filtered_q, crossover_predict(smp, clr)};
    endtask

    task automatic settle();
        smp_in_if.valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller lowers it after the last write
    task automatic cfg_write(input logic [lr4x_pkg::CFG_IDX_W-1:0] idx,
                             input lr4x_pkg::t_coef val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            lr4x_pkg::CFG_B0: tap_b0 = val;
            lr4x_pkg::CFG_B1: tap_b1 = val;
            lr4x_pkg::CFG_B2: tap_b2 = val;
            lr4x_pkg::CFG_A1: tap_a1 = val;
            lr4x_pkg::CFG_A2: tap_a2 = val;
            default: ;
        endcase
    endtask

    task automatic load_coefs(input lr4x_pkg::t_coef b0, b1, b2, a1, a2);
        cfg_write(lr4x_pkg::CFG_B0, b0);
        cfg_write(lr4x_pkg::CFG_B1, b1);
        cfg_write(lr4x_pkg::CFG_B2, b2);
        cfg_write(lr4x_pkg::CFG_A1, a1);
        cfg_write(lr4x_pkg::CFG_A2, a2);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_stream(input int count);
        for (int n = 0; n < count; n++)
            push_sample(pick_sample(), $urandom_range(0, 29) == 0);
        settle();
    endtask

    task automatic test_pass_through();
        push_sample('0, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(t_smp'(-1), 1'b0);
        push_sample(t_smp'(1), 1'b1);
        push_sample(24'h55_5555, 1'b0);
        push_sample(24'hAA_AAAA, 1'b0);
        settle();
    endtask

    // butterworth half of a linkwitz-riley pair, 220 Hz corner
    task automatic test_crossover(input bit highpass, input real fs, input int count);
        real w0, cs, alpha, a0, scale, b0, b1;
        w0    = 2.0 * 3.14159265358979 * 220.0 / fs;
        cs    = $cos(w0);
        alpha = $sin(w0) / (2.0 * 0.70710678118654752);
        a0    = 1.0 + alpha;
        scale = 2.0 ** lr4x_pkg::COEF_FRAC_BITS;
        b0    = (highpass ? (1.0 + cs) / 2.0 : (1.0 - cs) / 2.0) / a0;
        b1    = (highpass ? -(1.0 + cs) : (1.0 - cs)) / a0;
        load_coefs($rtoi(b0 * scale), $rtoi(b1 * scale), $rtoi(b0 * scale),
                   $rtoi(-2.0 * cs / a0 * scale), $rtoi((1.0 - alpha) / a0 * scale));
        run_stream(count);
    endtask

    task automatic test_start_flag();
        load_coefs(32'h0100_0000, 32'h0200_0000, 32'h0100_0000,
                   32'hE000_0000, 32'h0800_0000);
        repeat (4) push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(t_smp'(12345), 1'b1);
        settle();
    endtask

    task automatic test_spare_index();
        for (int i = lr4x_pkg::CFG_A2 + 1; i < 2 ** lr4x_pkg::CFG_IDX_W; i++)
            cfg_write(lr4x_pkg::CFG_IDX_W'(i), $urandom());
        i_cfg_we <= 1'b0;
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(t_smp'(-4096), 1'b0);
        settle();
    endtask

    // unstable feedback drives every stage into its rails
    task automatic test_saturation();
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        settle();
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        push_sample(SAMPLE_MIN, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        settle();
    endtask

    task automatic test_random_coefs(input int count);
        load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
        run_stream(count);
    endtask

    initial begin : out_check
        int   stall;
        t_smp want;
        smp_out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(SIDE_SNK);
            if (stall > 0) begin
                smp_out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            smp_out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (smp_out_if.valid !== 1'b1) @(posedge i_clk);
            // a transfer happened at this edge
            if (filtered_q.size() == 0) begin
                $error("sample_out: unexpected transfer, got %0d", smp_out_if.sample_out);
                err_count++;
            end else begin
                want = filtered_q.pop_front();
                if (smp_out_if.sample_out !== want) begin
                    $error("sample_out mismatch: expected %0d, got %0d",
                           want, smp_out_if.sample_out);
                    err_count++;
                end
            end
        end
    end

    initial begin
        err_count     = 0;
        cycle_count   = 0;
        calm_left[0]  = 0;
        calm_left[1]  = 0;
        tap_b0        = lr4x_pkg::COEF_ONE;
        tap_b1        = '0;
        tap_b2        = '0;
        tap_a1        = '0;
        tap_a2        = '0;
        clear_history();
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= lr4x_pkg::CFG_B0;
        i_cfg_data           <= '0;
        smp_in_if.valid      <= 1'b0;
        smp_in_if.sample_in  <= '0;
        smp_in_if.start_req  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pass_through();
        test_start_flag();
        test_spare_index();
        test_saturation();
        test_crossover(1'b0, 48000.0, 300);
        test_crossover(1'b1, 48000.0, 300);
        test_crossover(1'b0, 44100.0, 250);
        test_crossover(1'b1, 96000.0, 250);
        repeat (4) test_random_coefs(215);

        settle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0 && filtered_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
